FILE: rtl/core/ddls_pkg.sv
// ----------------------------------------------------------------------------
// Dawn/dusk light sequencer package
// Shared types and constants: transaction payloads, configuration registers,
// sequencer state and the phase and register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ddls_pkg;

	// Drive level limit and reset ramp interval.
	localparam logic [7:0]  LEVEL_TOP      = 8'd255;
	localparam logic [15:0] INTERVAL_RESET = 16'd7060;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Sequencer phases.
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SUNRISE = 2'd1,
		PH_DAY     = 2'd2,
		PH_SUNSET  = 2'd3
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ON_HOUR       = 3'd0,
		REG_ON_MINUTE     = 3'd1,
		REG_OFF_HOUR      = 3'd2,
		REG_OFF_MINUTE    = 3'd3,
		REG_MAX_LEVEL     = 3'd4,
		REG_TEMP_SETPOINT = 3'd5,
		REG_RAMP_INTERVAL = 3'd6
	} cfg_reg_t;

	// One input transaction.
	typedef struct packed {
		logic              manual_mode;
		logic [31:0]       now_ms;
		logic [4:0]        hour_now;
		logic [5:0]        minute_now;
		logic signed [7:0] avg_temp;
		logic [7:0]        manual_white;
		logic [7:0]        manual_redblue;
		logic [7:0]        manual_heat;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0] white_drive;
		logic [7:0] redblue_drive;
		logic [7:0] heat_drive;
		logic [1:0] phase_now;
	} rsp_t;

	// Configuration registers.
	typedef struct packed {
		logic [4:0]  on_hour;
		logic [5:0]  on_minute;
		logic [4:0]  off_hour;
		logic [5:0]  off_minute;
		logic [7:0]  max_level;
		logic [5:0]  temp_setpoint;
		logic [15:0] ramp_interval_ms;
	} cfg_t;

	// Sequencer and heater state.
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  redblue_level;
		logic [7:0]  white_level;
		logic        redblue_falling;
		logic        white_ramp_enable;
		logic [31:0] redblue_step_mark;
		logic [31:0] white_step_mark;
		logic        heater_on;
	} state_t;

	// Saturating single-count level steps.
	function automatic logic [7:0] inc_sat(input logic [7:0] v);
		return (v == LEVEL_TOP) ? LEVEL_TOP : v + 8'd1;
	endfunction

	function automatic logic [7:0] dec_sat(input logic [7:0] v);
		return (v == 8'd0) ? 8'd0 : v - 8'd1;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ddls_step.sv
// ----------------------------------------------------------------------------
// Dawn/dusk sequencer step logic
// Next state and drive values for one control pass: manual override, heater
// hysteresis, sunrise and sunset ramps and the midnight phase clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ddls_step
	import ddls_pkg::*;
(
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	input  wire req_t   req,
	output state_t      nxt,
	output rsp_t        rsp
);

	logic [31:0] rb_diff;
	logic [31:0] w_diff;
	logic [31:0] interval_ext;
	logic        rb_due;
	logic        w_due;
	logic        interval_zero;
	logic signed [8:0] temp_ext;
	logic signed [8:0] setpoint_ext;

	// Elapsed-time checks against the stored step marks.
	assign interval_ext  = {16'd0, cfg.ramp_interval_ms};
	assign rb_diff       = req.now_ms - cur.redblue_step_mark;
	assign w_diff        = req.now_ms - cur.white_step_mark;
	assign rb_due        = (rb_diff >= interval_ext);
	assign w_due         = (w_diff >= interval_ext);
	assign interval_zero = (cfg.ramp_interval_ms == 16'd0);
	assign temp_ext      = {req.avg_temp[7], req.avg_temp};
	assign setpoint_ext  = $signed({3'b000, cfg.temp_setpoint});

	// Sequencer pass: sunrise block first, then sunset block on its results.
	always_comb begin
		logic mark_set;
		logic rb_due_late;

		nxt         = cur;
		mark_set    = 1'b0;
		rb_due_late = rb_due;
		rsp.white_drive   = cur.white_level;
		rsp.redblue_drive = cur.redblue_level;
		rsp.heat_drive    = 8'd0;

		if (req.manual_mode) begin
			rsp.white_drive   = req.manual_white;
			rsp.redblue_drive = req.manual_redblue;
			rsp.heat_drive    = req.manual_heat;
		end else begin
			// Heater hysteresis: equal temperature keeps the present state.
			if (temp_ext < setpoint_ext) begin
				nxt.heater_on = 1'b1;
			end else if (temp_ext > setpoint_ext) begin
				nxt.heater_on = 1'b0;
			end
			rsp.heat_drive = nxt.heater_on ? LEVEL_TOP : 8'd0;

			// Sunrise start and sunrise ramps.
			if (req.hour_now >= cfg.on_hour && req.minute_now >= cfg.on_minute &&
				req.hour_now <= cfg.off_hour && cur.phase == PH_IDLE) begin
				nxt.phase         = PH_SUNRISE;
				nxt.redblue_level = inc_sat(cur.redblue_level);
			end else if (req.hour_now >= cfg.on_hour && cur.phase == PH_SUNRISE) begin
				if (rb_due && cur.redblue_level <= cfg.max_level && !cur.redblue_falling) begin
					if (cur.redblue_level >= cfg.max_level) begin
						nxt.redblue_falling   = 1'b1;
						nxt.white_ramp_enable = 1'b1;
					end else begin
						nxt.redblue_level = inc_sat(cur.redblue_level);
					end
					nxt.redblue_step_mark = req.now_ms;
					mark_set = 1'b1;
				end else if (rb_due && cur.redblue_falling) begin
					if (cur.redblue_level == 8'd0) begin
						nxt.phase = PH_DAY;
					end else begin
						nxt.redblue_level = dec_sat(cur.redblue_level);
					end
					nxt.redblue_step_mark = req.now_ms;
					mark_set = 1'b1;
				end
				if (w_due && cur.white_level < cfg.max_level && nxt.white_ramp_enable) begin
					nxt.white_level     = inc_sat(cur.white_level);
					nxt.white_step_mark = req.now_ms;
				end
			end

			// A mark just moved to now leaves a zero difference.
			rb_due_late = mark_set ? interval_zero : rb_due;

			// Sunset start and sunset ramps.
			if (req.hour_now >= cfg.off_hour && req.minute_now >= cfg.off_minute &&
				nxt.phase == PH_DAY) begin
				nxt.phase       = PH_SUNSET;
				nxt.white_level = dec_sat(nxt.white_level);
			end else if (req.hour_now >= cfg.off_hour && nxt.phase == PH_SUNSET) begin
				if (rb_due_late && nxt.redblue_falling) begin
					if (nxt.redblue_level >= cfg.max_level) begin
						nxt.redblue_falling   = 1'b0;
						nxt.white_ramp_enable = 1'b0;
					end else begin
						nxt.redblue_level = inc_sat(nxt.redblue_level);
					end
					nxt.white_level       = dec_sat(nxt.white_level);
					nxt.redblue_step_mark = req.now_ms;
				end else if (rb_due_late && !nxt.redblue_falling) begin
					nxt.redblue_level     = dec_sat(nxt.redblue_level);
					nxt.redblue_step_mark = req.now_ms;
				end
			end
		end

		// Midnight returns the sequencer to idle in either mode.
		if (req.hour_now == 5'd0 && req.minute_now == 6'd0) begin
			nxt.phase = PH_IDLE;
		end

		rsp.phase_now = nxt.phase;
	end

endmodule

`default_nettype wire

FILE: rtl/core/dawn_dusk_light_sequencer.sv
// ----------------------------------------------------------------------------
// Dawn/dusk light sequencer
// Lighting ramp sequencer with bang-bang heater control, one control pass
// per input transaction, with a configuration write port.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------
//  req      req_valid / req_ready  req (req_t), one control pass
//  rsp      rsp_valid / rsp_ready  rsp (rsp_t), drive levels
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// For each pass, state updates on acceptance and the result is
// registered, appearing the cycle after. A new pass is accepted every cycle
// while the result register is empty or being drained in the same cycle.
// Configuration writes are always accepted. Reset restores register defaults
// and clears the sequencer state; the result register starts empty.
//
`default_nettype none

module dawn_dusk_light_sequencer
	import ddls_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire                    rsp_ready,
	output rsp_t                   rsp,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_INDEX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	rsp_t   rsp_nxt;
	rsp_t   rsp_q;
	logic   rsp_valid_q;
	logic   req_fire;

	assign cfg_ready = 1'b1;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_hour          <= 5'd8;
			cfg_q.on_minute        <= 6'd0;
			cfg_q.off_hour         <= 5'd20;
			cfg_q.off_minute       <= 6'd0;
			cfg_q.max_level        <= LEVEL_TOP;
			cfg_q.temp_setpoint    <= 6'd25;
			cfg_q.ramp_interval_ms <= INTERVAL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ON_HOUR:       cfg_q.on_hour          <= cfg_data[4:0];
				REG_ON_MINUTE:     cfg_q.on_minute        <= cfg_data[5:0];
				REG_OFF_HOUR:      cfg_q.off_hour         <= cfg_data[4:0];
				REG_OFF_MINUTE:    cfg_q.off_minute       <= cfg_data[5:0];
				REG_MAX_LEVEL:     cfg_q.max_level        <= cfg_data[7:0];
				REG_TEMP_SETPOINT: cfg_q.temp_setpoint    <= cfg_data[5:0];
				REG_RAMP_INTERVAL: cfg_q.ramp_interval_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next-state and drive logic for one pass.
	ddls_step u_step (
		.cfg (cfg_q),
		.cur (state_q),
		.req (req),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// Sequencer state advances on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase             <= PH_IDLE;
			state_q.redblue_level     <= 8'd0;
			state_q.white_level       <= 8'd0;
			state_q.redblue_falling   <= 1'b0;
			state_q.white_ramp_enable <= 1'b0;
			state_q.redblue_step_mark <= 32'd0;
			state_q.white_step_mark   <= 32'd0;
			state_q.heater_on         <= 1'b0;
		end else if (req_fire) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_ready) begin
			rsp_valid_q <= req_valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Dawn/dusk light sequencer testbench
// Drives control passes through the request channel and checks every drive
// result against a cycle-free prediction of the sequencer and heater, or for
// some directed passes a fixed value. A short table of directed passes comes
// first, then well-formed simulated days with random content and some noise,
// under six register settings and three patterns of idling on the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import ddls_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DAY_PASSES   = 72;
	localparam int DAY_MINUTES  = 1440;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AFTER   = 40;

	typedef struct {
		req_t pass;
		bit   typed;
		rsp_t fixed;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_ready;
	req_t                   req;
	logic                   rsp_valid;
	logic                   rsp_ready;
	rsp_t                   rsp;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predicted sequencer state and register copy.
	cfg_t        model_cfg;
	phase_t      lit_phase = PH_IDLE;
	logic [7:0]  rb_lvl    = 8'd0;
	logic [7:0]  wh_lvl    = 8'd0;
	bit          rb_down   = 1'b0;
	bit          wh_climb  = 1'b0;
	logic [31:0] rb_mark   = 32'd0;
	logic [31:0] wh_mark   = 32'd0;
	bit          heat_on   = 1'b0;

	rsp_t        expected_drives[$];
	int          mismatches     = 0;
	int          passes_done    = 0;
	int          quiet_cycles   = 0;
	int          send_idle_pct  = 37;
	int          recv_idle_pct  = 60;

	// Simulated time of day for the well-formed passes.
	int          day_minute = 0;
	logic [31:0] ms_clock   = 32'd0;

	dawn_dusk_light_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] step_up(input logic [7:0] v);
		return (v >= LEVEL_TOP) ? LEVEL_TOP : v + 8'd1;
	endfunction

	function automatic logic [7:0] step_down(input logic [7:0] v);
		return (v == 8'd0) ? 8'd0 : v - 8'd1;
	endfunction

	// An interval has passed once the wrapped age reaches the ramp interval.
	function automatic bit interval_done(input logic [31:0] now, input logic [31:0] mark);
		logic [31:0] age;
		age = now - mark;
		return age >= {16'd0, model_cfg.ramp_interval_ms};
	endfunction

	function automatic cfg_t mk_settings(input int on_h, input int on_m, input int off_h,
			input int off_m, input int peak, input int setp, input int gap_ms);
		cfg_t s;
		s.on_hour          = 5'(on_h);
		s.on_minute        = 6'(on_m);
		s.off_hour         = 5'(off_h);
		s.off_minute       = 6'(off_m);
		s.max_level        = 8'(peak);
		s.temp_setpoint    = 6'(setp);
		s.ramp_interval_ms = 16'(gap_ms);
		return s;
	endfunction

	// Works out the drive levels of one control pass and moves the state on.
	function automatic rsp_t predict_drives(input req_t p);
		rsp_t r;
		int   temp_c;
		int   set_c;
		bit   rb_due;
		temp_c = int'(p.avg_temp);
		set_c  = int'(model_cfg.temp_setpoint);
		if (p.manual_mode) begin
			r.white_drive   = p.manual_white;
			r.redblue_drive = p.manual_redblue;
			r.heat_drive    = p.manual_heat;
		end else begin
			r.white_drive   = wh_lvl;
			r.redblue_drive = rb_lvl;
			if (temp_c < set_c)
				heat_on = 1'b1;
			else if (temp_c > set_c)
				heat_on = 1'b0;
			r.heat_drive = heat_on ? LEVEL_TOP : 8'd0;

			// Sunrise: red-blue climbs and falls back while white climbs.
			if (p.hour_now >= model_cfg.on_hour && p.minute_now >= model_cfg.on_minute &&
					p.hour_now <= model_cfg.off_hour && lit_phase == PH_IDLE) begin
				lit_phase = PH_SUNRISE;
				rb_lvl    = step_up(rb_lvl);
			end else if (p.hour_now >= model_cfg.on_hour && lit_phase == PH_SUNRISE) begin
				rb_due = interval_done(p.now_ms, rb_mark);
				if (rb_due && rb_lvl <= model_cfg.max_level && !rb_down) begin
					if (rb_lvl >= model_cfg.max_level) begin
						rb_down  = 1'b1;
						wh_climb = 1'b1;
					end else begin
						rb_lvl = step_up(rb_lvl);
					end
					rb_mark = p.now_ms;
				end else if (rb_due && rb_down) begin
					if (rb_lvl == 8'd0)
						lit_phase = PH_DAY;
					else
						rb_lvl = step_down(rb_lvl);
					rb_mark = p.now_ms;
				end
				if (interval_done(p.now_ms, wh_mark) && wh_lvl < model_cfg.max_level &&
						wh_climb) begin
					wh_lvl  = step_up(wh_lvl);
					wh_mark = p.now_ms;
				end
			end

			// Sunset: the reverse sweep, then red-blue back to zero.
			if (p.hour_now >= model_cfg.off_hour && p.minute_now >= model_cfg.off_minute &&
					lit_phase == PH_DAY) begin
				lit_phase = PH_SUNSET;
				wh_lvl    = step_down(wh_lvl);
			end else if (p.hour_now >= model_cfg.off_hour && lit_phase == PH_SUNSET) begin
				rb_due = interval_done(p.now_ms, rb_mark);
				if (rb_due && rb_down) begin
					if (rb_lvl >= model_cfg.max_level) begin
						rb_down  = 1'b0;
						wh_climb = 1'b0;
					end else begin
						rb_lvl = step_up(rb_lvl);
					end
					wh_lvl  = step_down(wh_lvl);
					rb_mark = p.now_ms;
				end else if (rb_due && !rb_down) begin
					rb_lvl  = step_down(rb_lvl);
					rb_mark = p.now_ms;
				end
			end
		end

		// Midnight clears the phase whatever the mode.
		if (p.hour_now == 5'd0 && p.minute_now == 6'd0)
			lit_phase = PH_IDLE;
		r.phase_now = lit_phase;
		return r;
	endfunction

	function automatic dir_row_t make_row(input bit manual, input logic [31:0] ms,
			input int hr, input int mn, input int temp, input logic [7:0] mw,
			input logic [7:0] mrb, input logic [7:0] mh, input bit typed,
			input logic [7:0] w, input logic [7:0] rb, input logic [7:0] h, input phase_t ph);
		dir_row_t row;
		row.pass.manual_mode    = manual;
		row.pass.now_ms         = ms;
		row.pass.hour_now       = 5'(hr);
		row.pass.minute_now     = 6'(mn);
		row.pass.avg_temp       = 8'(temp);
		row.pass.manual_white   = mw;
		row.pass.manual_redblue = mrb;
		row.pass.manual_heat    = mh;
		row.typed               = typed;
		row.fixed.white_drive   = w;
		row.fixed.redblue_drive = rb;
		row.fixed.heat_drive    = h;
		row.fixed.phase_now     = ph;
		return row;
	endfunction

	// Builds the next pass of a simulated day, now and then a noise pass instead.
	function automatic req_t next_pass();
		req_t p;
		int   step;
		int   spread;
		bit   ramping;
		p.manual_white   = 8'($urandom);
		p.manual_redblue = 8'($urandom);
		p.manual_heat    = 8'($urandom);
		p.manual_mode    = ($urandom_range(99) < 10);
		if ($urandom_range(99) < 8) begin
			p.now_ms     = $urandom;
			p.hour_now   = 5'($urandom);
			p.minute_now = 6'($urandom);
			p.avg_temp   = 8'($urandom);
		end else begin
			// The clock creeps while a ramp is running and jumps otherwise.
			ramping = (lit_phase == PH_SUNRISE) ||
				(lit_phase == PH_SUNSET && (rb_down || rb_lvl != 8'd0));
			if (ramping && $urandom_range(99) < 90)
				step = int'($urandom_range(2));
			else
				step = int'($urandom_range(120));
			day_minute += step;
			if (day_minute >= DAY_MINUTES)
				day_minute = 0;
			spread = 2 * int'(model_cfg.ramp_interval_ms) + 2;
			if ($urandom_range(99) < 2)
				ms_clock = 32'hFFFF_FFFF - $urandom_range(spread);
			else
				ms_clock = ms_clock + $urandom_range(spread);
			p.now_ms     = ms_clock;
			p.hour_now   = 5'(day_minute / 60);
			p.minute_now = 6'(day_minute % 60);
			if ($urandom_range(99) < 10)
				p.avg_temp = 8'($urandom);
			else
				p.avg_temp = 8'(int'(model_cfg.temp_setpoint) + int'($urandom_range(6)) - 3);
		end
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	// Offers one pass, waits for the transaction and queues what it should drive.
	task automatic send_pass(input req_t p, input bit typed, input rsp_t fixed);
		rsp_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= p;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = predict_drives(p);
		if (typed)
			want = fixed;
		expected_drives.push_back(want);
		passes_done++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		unique case (idx)
			REG_ON_HOUR:       model_cfg.on_hour          = val[4:0];
			REG_ON_MINUTE:     model_cfg.on_minute        = val[5:0];
			REG_OFF_HOUR:      model_cfg.off_hour         = val[4:0];
			REG_OFF_MINUTE:    model_cfg.off_minute       = val[5:0];
			REG_MAX_LEVEL:     model_cfg.max_level        = val[7:0];
			REG_TEMP_SETPOINT: model_cfg.temp_setpoint    = val[5:0];
			REG_RAMP_INTERVAL: model_cfg.ramp_interval_ms = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input cfg_t s);
		write_reg(REG_ON_HOUR, 16'(s.on_hour));
		write_reg(REG_ON_MINUTE, 16'(s.on_minute));
		write_reg(REG_OFF_HOUR, 16'(s.off_hour));
		write_reg(REG_OFF_MINUTE, 16'(s.off_minute));
		write_reg(REG_MAX_LEVEL, 16'(s.max_level));
		write_reg(REG_TEMP_SETPOINT, 16'(s.temp_setpoint));
		write_reg(REG_RAMP_INTERVAL, s.ramp_interval_ms);
		cfg_valid <= 1'b0;
	endtask

	// Lowers the request and waits until every queued result has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (expected_drives.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, with one long hold-off once traffic is under way.
	initial begin : result_sink
		bit held;
		held      = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && passes_done >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every result transaction is checked against the oldest expectation.
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_drives.size() == 0) begin
				report_mismatch($sformatf("result %p with nothing expected", rsp));
			end else begin
				want = expected_drives.pop_front();
				if (rsp.white_drive !== want.white_drive)
					report_mismatch($sformatf("white_drive %0d, expected %0d",
						rsp.white_drive, want.white_drive));
				if (rsp.redblue_drive !== want.redblue_drive)
					report_mismatch($sformatf("redblue_drive %0d, expected %0d",
						rsp.redblue_drive, want.redblue_drive));
				if (rsp.heat_drive !== want.heat_drive)
					report_mismatch($sformatf("heat_drive %0d, expected %0d",
						rsp.heat_drive, want.heat_drive));
				if (rsp.phase_now !== want.phase_now)
					report_mismatch($sformatf("phase_now %0d, expected %0d",
						rsp.phase_now, want.phase_now));
			end
		end
	end

	// Watchdog on cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t rows[$];
		cfg_t     day_settings[6];
		rsp_t     none;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ON_HOUR;
		cfg_data  = '0;
		none      = '0;
		model_cfg = mk_settings(8, 0, 20, 0, int'(LEVEL_TOP), 25, int'(INTERVAL_RESET));

		// Mid settings with short ramps, then the minima, the maxima and
		// hour and minute values that never occur on a clock.
		day_settings[0] = mk_settings(6, 15, 18, 30, 5, 25, 10);
		day_settings[1] = mk_settings(0, 0, 0, 0, 0, 0, 0);
		day_settings[2] = mk_settings(7, 30, 19, 45, 3, 50, 1);
		day_settings[3] = mk_settings(23, 45, 23, 45, 255, 50, 65535);
		day_settings[4] = mk_settings(5, 0, 31, 63, 1, 63, 100);
		day_settings[5] = mk_settings(0, 45, 23, 0, 8, 30, 2000);

		// Directed passes under the reset settings.
		rows.push_back(make_row(0, 32'd0, 3, 0, 25, 8'h00, 8'h00, 8'h00,
			1, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(1, 32'd0, 3, 0, 0, 8'hFF, 8'hFF, 8'hFF,
			1, 8'hFF, 8'hFF, 8'hFF, PH_IDLE));
		rows.push_back(make_row(1, 32'd0, 3, 0, 0, 8'h00, 8'h00, 8'h00,
			1, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'd0, 3, 0, -128, 8'h00, 8'h00, 8'h00,
			1, 8'd0, 8'd0, 8'hFF, PH_IDLE));
		rows.push_back(make_row(0, 32'd0, 3, 0, 25, 8'h00, 8'h00, 8'h00,
			1, 8'd0, 8'd0, 8'hFF, PH_IDLE));
		rows.push_back(make_row(0, 32'd0, 3, 0, 127, 8'h00, 8'h00, 8'h00,
			1, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'd0, 8, 0, 24, 8'h00, 8'h00, 8'h00,
			1, 8'd0, 8'd0, 8'hFF, PH_SUNRISE));
		rows.push_back(make_row(0, 32'd7059, 8, 1, 26, 8'hFF, 8'hFF, 8'hFF,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'd7060, 8, 2, 25, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'hFFFF_FFFF, 9, 0, 0, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'h0000_0FFF, 9, 15, 30, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(1, 32'd20000, 10, 0, 25, 8'hA5, 8'h5A, 8'h3C,
			1, 8'hA5, 8'h5A, 8'h3C, PH_SUNRISE));
		rows.push_back(make_row(0, 32'h8000_0000, 31, 63, 80, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'h8000_4000, 0, 0, 20, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(1, 32'h8000_8000, 0, 0, 20, 8'h11, 8'h22, 8'h33,
			1, 8'h11, 8'h22, 8'h33, PH_IDLE));
		rows.push_back(make_row(0, 32'h8001_0000, 23, 59, 80, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'h8002_0000, 20, 0, -40, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'h7FFF_FFFF, 20, 0, 25, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));
		rows.push_back(make_row(0, 32'h0001_0000, 0, 63, 25, 8'h00, 8'h00, 8'h00,
			0, 8'd0, 8'd0, 8'd0, PH_IDLE));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_pass(rows[i].pass, rows[i].typed, rows[i].fixed);

		// Simulated days, two settings per pattern of idling.
		for (int seg = 0; seg < 6; seg++) begin
			drain();
			send_idle_pct = (seg < 2) ? 37 : ((seg < 4) ? 60 : 0);
			recv_idle_pct = (seg < 2) ? 60 : ((seg < 4) ? 37 : 0);
			load_settings(day_settings[seg]);
			repeat (DAY_PASSES)
				send_pass(next_pass(), 1'b0, none);
		end
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && expected_drives.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/ddls_pkg.sv
rtl/core/ddls_step.sv
rtl/core/dawn_dusk_light_sequencer.sv
verif/tb.sv
